>>> sv/tcpq_pkg.sv
// tcpq_pkg: shared types, codes and constants of the three-class priority queue
// no dependencies
package tcpq_pkg;

  localparam int unsigned QueueDepthDefault = 32;

  localparam logic [6:0]  SeniorAgeReset = 7'd60;
  localparam logic [15:0] WaitLimitReset = 16'd120;

  typedef enum logic [2:0] {
    REQ_ENQUEUE = 3'd0,
    REQ_SERVE   = 3'd1,
    REQ_AGING   = 3'd2,
    REQ_PROMOTE = 3'd3,
    REQ_REMOVE  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_SENIOR_AGE = 2'd0,
    CFG_WAIT_LIMIT = 2'd1
  } cfg_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DRAIN,
    FSM_DONE
  } fsm_e;

  localparam logic [1:0] CLS_EMERG = 2'd0;
  localparam logic [1:0] CLS_PRIO  = 2'd1;
  localparam logic [1:0] CLS_NORM  = 2'd2;

  localparam logic [1:0] GRP_FIRST  = 2'd0;
  localparam logic [1:0] GRP_SECOND = 2'd1;
  localparam logic [1:0] GRP_THIRD  = 2'd2;
  localparam logic [1:0] GRP_LAST   = 2'd3;

  typedef struct packed {
    logic [15:0] ticket;
    logic [15:0] stamp;
    logic [1:0]  cls;
  } entry_t;

  typedef struct packed {
    logic en;
    logic bank;
  } mem_wr_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_ticket;
    logic [1:0]  out_class;
    logic [5:0]  occupancy;
  } rsp_t;

endpackage

>>> sv/tcpq_if.sv
// tcpq_if: valid/ready channel interfaces for requests, responses and config writes
// no dependencies
interface tcpq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] ticket;
  logic [6:0]  age;
  logic        health_worker;
  logic [15:0] time_value;
  modport source (output valid, req_type, ticket, age, health_worker, time_value,
                  input ready);
  modport sink (input valid, req_type, ticket, age, health_worker, time_value,
                output ready);
endinterface

interface tcpq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_ticket;
  logic [1:0]  out_class;
  logic [5:0]  occupancy;
  modport source (output valid, status, out_ticket, out_class, occupancy, input ready);
  modport sink (input valid, status, out_ticket, out_class, occupancy, output ready);
endinterface

interface tcpq_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/three_class_priority_queue.sv
// three_class_priority_queue: ordered ticket queue in three classes with aging
// depends on tcpq_pkg, tcpq_if, tcpq_store
//
// channels: req_i takes one request transaction (enqueue, serve, aging check,
// emergency promote, remove), rsp_o gives exactly one response transaction per
// request, cfg_i writes senior_age (index 0) or wait_limit (index 1).
// every operation that touches the queue rebuilds it from one memory bank into
// the other: four passes over the entries, one entry read per cycle through the
// registered memory read port. full enqueue, serve on empty and unknown requests
// answer without a pass over the memory. one request is worked on at a time; a
// finished response waits in the output register while the next request is
// accepted and processed. reset empties the queue (entry count zero) and loads
// senior_age 60 and wait_limit 120; memory contents are not cleared.
// when the receiver stalls the response holds, and a following request stops
// before delivering its own response until the output register is free.
module three_class_priority_queue
  import tcpq_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  tcpq_req_if.sink   req_i,
  tcpq_rsp_if.source rsp_o,
  tcpq_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = $clog2(QueueDepth);
  localparam int unsigned CW = $clog2(QueueDepth + 1);

  fsm_e        state_q, state_d;
  logic        bank_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] idx_q;
  logic [1:0]  grp_q;
  logic        tv_q;
  logic [1:0]  tg_q;
  logic [CW-1:0] ti_q;
  logic [CW-1:0] wptr_q;
  logic        found_q;
  logic        flip_q;
  logic        out_valid_q;
  logic [6:0]  senior_q;
  logic [15:0] limit_q;

  req_e        op_q;
  logic [15:0] tk_q;
  logic [6:0]  age_q;
  logic        hw_q;
  logic [15:0] time_q;
  logic [15:0] otk_q;
  logic [1:0]  ocls_q;
  logic [1:0]  status_q;
  rsp_t        out_q;

  entry_t      rd_data;
  entry_t      wdata;
  entry_t      new_entry;
  entry_t      wr_data;
  mem_wr_t     mem_wr;
  logic [1:0]  g_old;
  logic [1:0]  g_new;
  logic        drop;
  logic        match;
  logic        aged;
  logic [15:0] wait_time;
  logic        in_range;
  logic        write_old;
  logic        write_new;
  logic        req_acc;
  logic        immediate;
  logic [1:0]  imm_status;
  logic        leave_done;
  logic [CW-1:0] count_new;
  logic [1:0]  final_status;

  tcpq_store #(.Depth(QueueDepth)) u_store (
    .clk_i     (clk_i),
    .rd_bank_i (bank_q),
    .rd_addr_i (idx_q[AW-1:0]),
    .wr_i      (mem_wr),
    .wr_addr_i (wptr_q[AW-1:0]),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  assign wr_data = write_new ? new_entry : wdata;

  assign req_acc = req_i.valid && req_i.ready;

  always_comb begin
    immediate  = 1'b0;
    imm_status = STAT_OK;
    case (req_i.req_type)
      REQ_ENQUEUE: begin
        if (count_q == CW'(QueueDepth)) begin
          immediate  = 1'b1;
          imm_status = STAT_FULL;
        end
      end
      REQ_SERVE: begin
        if (count_q == '0) begin
          immediate  = 1'b1;
          imm_status = STAT_EMPTY;
        end
      end
      REQ_AGING, REQ_PROMOTE, REQ_REMOVE: begin
        immediate = 1'b0;
      end
      default: begin
        immediate = 1'b1;
      end
    endcase
  end

  // data stage: classify the entry read in the previous cycle
  assign match     = (rd_data.ticket == tk_q);
  assign wait_time = time_q - rd_data.stamp;
  assign aged      = (wait_time > limit_q);
  assign in_range  = (ti_q != count_q);
  assign g_new     = ((age_q >= senior_q) || hw_q) ? GRP_SECOND : GRP_THIRD;

  always_comb begin
    new_entry.ticket = tk_q;
    new_entry.stamp  = time_q;
    new_entry.cls    = (g_new == GRP_SECOND) ? CLS_PRIO : CLS_NORM;
  end

  always_comb begin
    wdata = rd_data;
    drop  = 1'b0;
    g_old = GRP_FIRST;
    case (op_q)
      REQ_ENQUEUE: begin
        g_old = (rd_data.cls == CLS_EMERG) ? GRP_FIRST :
                (rd_data.cls == CLS_PRIO) ? GRP_SECOND : GRP_THIRD;
      end
      REQ_SERVE: begin
        drop = (ti_q == '0);
      end
      REQ_AGING: begin
        if (rd_data.cls == CLS_EMERG) begin
          g_old = GRP_FIRST;
        end else if (aged) begin
          g_old     = GRP_SECOND;
          wdata.cls = CLS_PRIO;
        end else if (rd_data.cls == CLS_PRIO) begin
          g_old = GRP_THIRD;
        end else begin
          g_old = GRP_LAST;
        end
      end
      REQ_PROMOTE: begin
        if (match) begin
          g_old     = GRP_SECOND;
          wdata.cls = CLS_EMERG;
        end else begin
          g_old = (rd_data.cls == CLS_EMERG) ? GRP_FIRST : GRP_THIRD;
        end
      end
      REQ_REMOVE: begin
        drop = match;
      end
      default: begin
        drop = 1'b1;
      end
    endcase
  end

  assign write_old = tv_q && in_range && !drop && (g_old == tg_q);
  assign write_new = tv_q && !in_range && (op_q == REQ_ENQUEUE) && (tg_q == g_new);

  assign leave_done = (state_q == FSM_DONE) && (!out_valid_q || rsp_o.ready);
  assign count_new  = flip_q ? wptr_q : count_q;
  assign final_status = (flip_q && ((op_q == REQ_PROMOTE) || (op_q == REQ_REMOVE))
                         && !found_q) ? STAT_NOT_FOUND : status_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (req_acc) begin
          state_d = immediate ? FSM_DONE : FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if ((idx_q == count_q) && (grp_q == GRP_LAST)) begin
          state_d = FSM_DRAIN;
        end
      end
      FSM_DRAIN: begin
        state_d = FSM_DONE;
      end
      FSM_DONE: begin
        if (leave_done) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    req_i.ready       = (state_q == FSM_IDLE);
    cfg_i.ready       = 1'b1;
    mem_wr.en         = write_old || write_new;
    mem_wr.bank       = ~bank_q;
    rsp_o.valid       = out_valid_q;
    rsp_o.status      = out_q.status;
    rsp_o.out_ticket  = out_q.out_ticket;
    rsp_o.out_class   = out_q.out_class;
    rsp_o.occupancy   = out_q.occupancy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      bank_q      <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      grp_q       <= GRP_FIRST;
      tv_q        <= 1'b0;
      wptr_q      <= '0;
      found_q     <= 1'b0;
      flip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      senior_q    <= SeniorAgeReset;
      limit_q     <= WaitLimitReset;
    end else begin
      state_q <= state_d;
      tv_q    <= (state_q == FSM_SCAN);
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_SENIOR_AGE: senior_q <= cfg_i.data[6:0];
          CFG_WAIT_LIMIT: limit_q  <= cfg_i.data;
          default: ;
        endcase
      end
      if (req_acc) begin
        idx_q   <= '0;
        grp_q   <= GRP_FIRST;
        wptr_q  <= '0;
        found_q <= 1'b0;
        flip_q  <= !immediate;
      end
      if (state_q == FSM_SCAN) begin
        if (idx_q == count_q) begin
          idx_q <= '0;
          grp_q <= grp_q + 2'd1;
        end else begin
          idx_q <= idx_q + CW'(1);
        end
      end
      if (mem_wr.en) begin
        wptr_q <= wptr_q + CW'(1);
      end
      if (tv_q && in_range && (tg_q == GRP_FIRST) && match) begin
        found_q <= 1'b1;
      end
      if (rsp_o.valid && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (leave_done) begin
        out_valid_q <= 1'b1;
        count_q     <= count_new;
        if (flip_q) begin
          bank_q <= ~bank_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tg_q <= grp_q;
    ti_q <= idx_q;
    if (req_acc) begin
      op_q     <= req_e'(req_i.req_type);
      tk_q     <= req_i.ticket;
      age_q    <= req_i.age;
      hw_q     <= req_i.health_worker;
      time_q   <= req_i.time_value;
      otk_q    <= '0;
      ocls_q   <= '0;
      status_q <= imm_status;
    end
    if (tv_q && in_range && (tg_q == GRP_FIRST)) begin
      if ((op_q == REQ_SERVE) && (ti_q == '0)) begin
        otk_q  <= rd_data.ticket;
        ocls_q <= rd_data.cls;
      end
      if ((op_q == REQ_REMOVE) && match && !found_q) begin
        otk_q  <= rd_data.ticket;
        ocls_q <= rd_data.cls;
      end
    end
    if (leave_done) begin
      out_q.status     <= final_status;
      out_q.out_ticket <= otk_q;
      out_q.out_class  <= ocls_q;
      out_q.occupancy  <= 6'(count_new);
    end
  end

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_IDLE) |-> !mem_wr.en)
    else $error("memory write while idle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CW'(QueueDepth)) && (wptr_q <= CW'(QueueDepth)))
    else $error("entry count beyond depth");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (state_q != FSM_IDLE))
    else $error("request accepted but block stayed idle");

  a_enqueue_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (leave_done && flip_q && (op_q == REQ_ENQUEUE)) |-> (wptr_q == count_q + CW'(1)))
    else $error("enqueue did not add exactly one entry");

endmodule

>>> sv/tcpq_store.sv
// tcpq_store: two banks of entry memory, one write and one registered read per cycle
// depends on tcpq_pkg
module tcpq_store
  import tcpq_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          rd_bank_i,
  input  logic [AW-1:0] rd_addr_i,
  input  mem_wr_t       wr_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  output entry_t        rd_data_o
);

  entry_t bank0_q [Depth];
  entry_t bank1_q [Depth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      if (wr_i.bank) begin
        bank1_q[wr_addr_i] <= wr_data_i;
      end else begin
        bank0_q[wr_addr_i] <= wr_data_i;
      end
    end
    rd_data_q <= rd_bank_i ? bank1_q[rd_addr_i] : bank0_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
